### sv/tlg_pkg.sv
// ----------------------------------------------------------------------------
// tlg_pkg
// Shared sizes, codes and types for the toroidal life generation core.
// ----------------------------------------------------------------------------
package tlg_pkg;

    localparam int COLS   = 32;
    localparam int ROWS   = 32;
    localparam int COL_AW = $clog2(COLS);
    localparam int ROW_AW = $clog2(ROWS);

    // operation codes carried in s_tuser
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_STEP  = 2'd2;

    typedef logic [COLS-1:0] row_t;

    typedef struct packed {
        logic              shift;
        logic              wr;
        logic [COL_AW-1:0] col;
        logic              value;
    } cell_ctrl_t;

endpackage

### sv/tlg_row_cell.sv
// ----------------------------------------------------------------------------
// tlg_row_cell
// One grid row in the ring: takes its neighbor's row on a shift, or has a
// single bit written.
// ----------------------------------------------------------------------------
module tlg_row_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  tlg_pkg::cell_ctrl_t ctrl,
    input  tlg_pkg::row_t      shift_in,
    output tlg_pkg::row_t      row_q
);
    import tlg_pkg::*;

    row_t row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            row_reg <= shift_in;
        end
        else if (ctrl.wr)
        begin
            row_reg[ctrl.col] <= ctrl.value;
        end
    end

    assign row_q = row_reg;

endmodule

### sv/tlg_row_update.sv
// ----------------------------------------------------------------------------
// tlg_row_update
// B3/S23 rule for one whole row from the rows above, at and below it.
// Columns wrap around.
// ----------------------------------------------------------------------------
module tlg_row_update (
    input  tlg_pkg::row_t above,
    input  tlg_pkg::row_t cur,
    input  tlg_pkg::row_t below,
    output tlg_pkg::row_t new_row
);
    import tlg_pkg::*;

    for (genvar c = 0; c < COLS; c++)
    begin : g_col
        localparam int L = (c == 0) ? COLS - 1 : c - 1;
        localparam int R = (c == COLS - 1) ? 0 : c + 1;
        logic [3:0] cnt;

        always_comb
        begin
            cnt = 4'({3'b0, above[L]}) + 4'({3'b0, above[c]}) + 4'({3'b0, above[R]})
                + 4'({3'b0, cur[L]})   + 4'({3'b0, cur[R]})
                + 4'({3'b0, below[L]}) + 4'({3'b0, below[c]}) + 4'({3'b0, below[R]});
        end

        assign new_row[c] = (cnt == 4'd3) | (cur[c] & (cnt == 4'd2));
    end

endmodule

### sv/toroidal_life_generation_core.sv
// ----------------------------------------------------------------------------
// toroidal_life_generation_core
// Life grid on a torus, held as a ring of row cells; cell writes, reads and
// whole-grid generation steps.
// ----------------------------------------------------------------------------
// Latency: write/read result is presented the cycle after the input transfer;
//   a generation step gives its result after the step and finish states.
// Throughput: one write/read per cycle unless the output stalls; a step
//   holds the core for one turn of the row ring through the single rule unit.
// Reset (rst_n low, asynchronous): all cells dead, output empty, core idle.
// ----------------------------------------------------------------------------
module toroidal_life_generation_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // col[4:0], row[9:5], value[10], zero[15:11]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // cell_value[0], zero[7:1]
);
    import tlg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_STEP   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [ROW_AW-1:0] step_cnt_reg;
    row_t              prev_reg;
    row_t              row0_reg;
    logic [COL_AW-1:0] addr_col_reg;
    logic [ROW_AW-1:0] addr_row_reg;
    logic              inside_reg;
    logic              m_tvalid_reg;
    logic              cell_value_reg;

    logic [1:0]        in_func;
    logic [4:0]        in_col;
    logic [4:0]        in_row;
    logic              in_value;
    logic              in_inside;
    logic              in_xfer;

    row_t              cell_q [ROWS];
    cell_ctrl_t        ctrl   [ROWS];
    row_t              below;
    row_t              new_row;
    logic [COL_AW-1:0] rd_col;
    logic [ROW_AW-1:0] rd_row;
    logic              rd_bit;

    assign in_func   = s_tuser;
    assign in_col    = s_tdata[4:0];
    assign in_row    = s_tdata[9:5];
    assign in_value  = s_tdata[10];
    assign in_inside = (int'(in_col) < COLS) && (int'(in_row) < ROWS);

    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign in_xfer  = s_tvalid && s_tready;

    // row ring
    for (genvar i = 0; i < ROWS; i++)
    begin : g_cell
        row_t shift_src;

        if (i == ROWS - 1)
        begin : g_tail
            assign shift_src = new_row;
        end
        else
        begin : g_body
            assign shift_src = cell_q[i+1];
        end

        always_comb
        begin
            ctrl[i].shift = (state_reg == S_STEP);
            ctrl[i].wr    = in_xfer && (in_func == FUNC_WRITE) && in_inside
                            && (in_row[ROW_AW-1:0] == ROW_AW'(i));
            ctrl[i].col   = in_col[COL_AW-1:0];
            ctrl[i].value = in_value;
        end

        tlg_row_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl[i]),
            .shift_in (shift_src),
            .row_q    (cell_q[i])
        );
    end

    // the last row's lower neighbor is the old row 0, saved before it left
    assign below = (step_cnt_reg == ROW_AW'(ROWS - 1)) ? row0_reg : cell_q[1];

    tlg_row_update u_update (
        .above   (prev_reg),
        .cur     (cell_q[0]),
        .below   (below),
        .new_row (new_row)
    );

    assign rd_col = (state_reg == S_IDLE) ? in_col[COL_AW-1:0] : addr_col_reg;
    assign rd_row = (state_reg == S_IDLE) ? in_row[ROW_AW-1:0] : addr_row_reg;
    assign rd_bit = cell_q[rd_row][rd_col];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (in_func == FUNC_STEP))
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (step_cnt_reg == ROW_AW'(ROWS - 1))
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            step_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_STEP)
            begin
                step_cnt_reg <= (step_cnt_reg == ROW_AW'(ROWS - 1)) ? '0
                                : step_cnt_reg + 1'b1;
            end
            if ((in_xfer && (in_func != FUNC_STEP)) || (state_reg == S_FINISH))
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            addr_col_reg <= in_col[COL_AW-1:0];
            addr_row_reg <= in_row[ROW_AW-1:0];
            inside_reg   <= in_inside;
            prev_reg     <= cell_q[ROWS-1];
            row0_reg     <= cell_q[0];
        end
        else if (state_reg == S_STEP)
        begin
            prev_reg <= cell_q[0];
        end

        if (in_xfer && (in_func != FUNC_STEP))
        begin
            if (!in_inside)
            begin
                cell_value_reg <= 1'b0;
            end
            else if (in_func == FUNC_WRITE)
            begin
                cell_value_reg <= in_value;
            end
            else
            begin
                cell_value_reg <= rd_bit;
            end
        end
        else if (state_reg == S_FINISH)
        begin
            cell_value_reg <= inside_reg & rd_bit;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, cell_value_reg};

    // a step hands over to the result state right after the last row
    a_step_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP && step_cnt_reg == ROW_AW'(ROWS - 1)) |=> state_reg == S_FINISH)
        else $error("step did not finish after the last row");

    // the output slot is free when a step result is loaded
    a_finish_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |-> !m_tvalid_reg)
        else $error("step result would overwrite a pending result");

    // row counter is parked at zero outside a step
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_STEP) |-> step_cnt_reg == '0)
        else $error("row counter moved outside a step");

    // no input transfer while the ring is rotating
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("input ready while busy");

endmodule
